@@ rtl/radial_mask_background_subtract_assert.svh @@
// Assertion macros shared by the radial mask background subtraction RTL.
`ifndef RADIAL_MASK_BACKGROUND_SUBTRACT_ASSERT_SVH
`define RADIAL_MASK_BACKGROUND_SUBTRACT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RMBS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rmbs: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define RMBS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rmbs: next-cycle check failed");

`endif

@@ rtl/rmbs_pkg.sv @@
// Shared constants, types and codes of the radial mask background subtraction block.
package rmbs_pkg;
	localparam int MaxWidth  = 640;
	localparam int MaxHeight = 480;
	localparam int BgDepth   = MaxWidth * MaxHeight;
	localparam int AddrW     = $clog2(BgDepth);
	localparam int PixW      = 8;
	localparam int ColW      = 10;
	localparam int RowW      = 9;
	localparam int RadW      = 10;
	localparam int ThrW      = 8;
	localparam int CfgIdxW   = 3;
	localparam int CfgDataW  = 10;
	localparam int D2W       = 21;
	localparam int VW        = D2W + 16;
	localparam int DistW     = 19;
	localparam int DenW      = RadW + 8;
	localparam int NumW      = DistW + 8;
	localparam int LinW      = RowW + ColW + 1;
	localparam int QDepth    = 4;
	localparam int QPtrW     = $clog2(QDepth);

	typedef enum logic [CfgIdxW-1:0] {
		CFG_CENTER_X     = 3'd0,
		CFG_CENTER_Y     = 3'd1,
		CFG_INNER_RADIUS = 3'd2,
		CFG_OUTER_RADIUS = 3'd3,
		CFG_THRESHOLD    = 3'd4,
		CFG_FRAME_WIDTH  = 3'd5,
		CFG_FRAME_HEIGHT = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [ColW-1:0] center_x;
		logic [ColW-1:0] center_y;
		logic [RadW-1:0] inner_radius;
		logic [RadW-1:0] outer_radius;
		logic [ThrW-1:0] threshold;
		logic [ColW-1:0] frame_width;
		logic [RowW-1:0] frame_height;
	} cfg_t;

	typedef struct packed {
		logic [PixW-1:0] pixel;
		logic            capture_bg;
		logic [ColW-1:0] col;
		logic [RowW-1:0] row;
		logic            frame_end;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic clearing;
	} back_status_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SQR,
		ST_SQRT,
		ST_RAMP,
		ST_DIV,
		ST_MEM,
		ST_CMP,
		ST_OUT
	} bstate_t;
endpackage

@@ rtl/rmbs_ifs.sv @@
// Handshake channels of the block: pixel requests, result requests and register writes.
interface rmbs_pix_if;
	logic                      valid;
	logic                      ready;
	logic [rmbs_pkg::PixW-1:0] pixel;
	logic                      capture_bg;
	logic                      frame_start;
	modport source (output valid, pixel, capture_bg, frame_start, input ready);
	modport sink (input valid, pixel, capture_bg, frame_start, output ready);
endinterface

interface rmbs_res_if;
	logic                      valid;
	logic                      ready;
	logic [rmbs_pkg::PixW-1:0] foreground;
	logic [rmbs_pkg::PixW-1:0] masked_pixel;
	logic [rmbs_pkg::PixW-1:0] mask_value;
	logic                      frame_end;
	modport source (output valid, foreground, masked_pixel, mask_value, frame_end, input ready);
	modport sink (input valid, foreground, masked_pixel, mask_value, frame_end, output ready);
endinterface

interface rmbs_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [rmbs_pkg::CfgIdxW-1:0]  index;
	logic [rmbs_pkg::CfgDataW-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/rmbs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rmbs_ram #(
	parameter int Width = 8,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/rmbs_queue.sv @@
// Short queue of classified pixel requests between the front and back parts.
module rmbs_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  rmbs_pkg::item_t     push_item,
	input  logic                pop,
	output rmbs_pkg::item_t     head,
	output rmbs_pkg::q_status_t status
);
	rmbs_pkg::item_t                entries_q [rmbs_pkg::QDepth];
	logic [rmbs_pkg::QPtrW-1:0]    wr_ptr_q;
	logic [rmbs_pkg::QPtrW-1:0]    rd_ptr_q;
	logic [rmbs_pkg::QPtrW:0]      count_q;

	assign head         = entries_q[rd_ptr_q];
	assign status.full  = (count_q == (rmbs_pkg::QPtrW+1)'(rmbs_pkg::QDepth));
	assign status.empty = (count_q == '0);

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end
endmodule

@@ rtl/rmbs_front.sv @@
// Front part: accepts pixel requests and tags each with its position and frame end.
module rmbs_front (
	input  logic                   clk,
	input  logic                   arst_n,
	rmbs_pix_if.sink               pixels,
	input  rmbs_pkg::cfg_t         cfg_regs,
	input  rmbs_pkg::q_status_t    q_status,
	input  rmbs_pkg::back_status_t back_status,
	output logic                   push,
	output rmbs_pkg::item_t        push_item
);
	logic [rmbs_pkg::ColW-1:0] col_q;
	logic [rmbs_pkg::RowW-1:0] row_q;
	logic [rmbs_pkg::ColW-1:0] col;
	logic [rmbs_pkg::RowW-1:0] row;
	logic [rmbs_pkg::ColW:0]   w_eff;
	logic [rmbs_pkg::RowW:0]   h_eff;
	logic                      line_end;
	logic                      frame_end;

	assign pixels.ready = !q_status.full && !back_status.clearing;
	assign push         = pixels.valid && pixels.ready;

	// Effective frame size: a zero becomes one, and larger values are clamped to the store's dimensions.
	always_comb begin
		if (cfg_regs.frame_width == '0) begin
			w_eff = (rmbs_pkg::ColW+1)'(1);
		end else if ({1'b0, cfg_regs.frame_width} > (rmbs_pkg::ColW+1)'(rmbs_pkg::MaxWidth)) begin
			w_eff = (rmbs_pkg::ColW+1)'(rmbs_pkg::MaxWidth);
		end else begin
			w_eff = {1'b0, cfg_regs.frame_width};
		end
		if (cfg_regs.frame_height == '0) begin
			h_eff = (rmbs_pkg::RowW+1)'(1);
		end else if ({1'b0, cfg_regs.frame_height} > (rmbs_pkg::RowW+1)'(rmbs_pkg::MaxHeight)) begin
			h_eff = (rmbs_pkg::RowW+1)'(rmbs_pkg::MaxHeight);
		end else begin
			h_eff = {1'b0, cfg_regs.frame_height};
		end
	end

	// Position of this pixel and end-of-line and end-of-frame detection.
	always_comb begin
		col       = pixels.frame_start ? '0 : col_q;
		row       = pixels.frame_start ? '0 : row_q;
		line_end  = ({1'b0, col} + 1'b1) >= w_eff;
		frame_end = line_end && (({1'b0, row} + 1'b1) >= h_eff);
		push_item = '{pixel: pixels.pixel, capture_bg: pixels.capture_bg,
			col: col, row: row, frame_end: frame_end};
	end

	// Raster counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (line_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row + 1'b1;
			end else begin
				col_q <= col + 1'b1;
				row_q <= row;
			end
		end
	end
endmodule

@@ rtl/rmbs_back.sv @@
// Back part: distance, ramp mask, saturation and background comparison, one request at a time.
`include "radial_mask_background_subtract_assert.svh"

module rmbs_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rmbs_pkg::cfg_t         cfg_regs,
	input  rmbs_pkg::q_status_t    q_status,
	input  rmbs_pkg::item_t        head,
	output logic                   pop,
	output rmbs_pkg::back_status_t back_status,
	rmbs_res_if.source             results
);
	rmbs_pkg::bstate_t state_q, state_d;

	rmbs_pkg::item_t                 item_q;
	logic [rmbs_pkg::VW-1:0]         v_q;
	logic [rmbs_pkg::VW-1:0]         res_q;
	logic [rmbs_pkg::VW-1:0]         bit_q;
	logic [rmbs_pkg::PixW-1:0]       mask_q;
	logic [rmbs_pkg::NumW-1:0]       rem_q;
	logic [rmbs_pkg::NumW-1:0]       dsh_q;
	logic [2:0]                      dcnt_q;
	logic [rmbs_pkg::PixW-1:0]       sum_q;
	logic [rmbs_pkg::AddrW-1:0]      addr_q;
	logic [rmbs_pkg::AddrW-1:0]      clr_q;
	logic [rmbs_pkg::PixW-1:0]       fg_q;

	logic signed [rmbs_pkg::ColW:0]     dx;
	logic signed [rmbs_pkg::ColW:0]     dy;
	logic signed [2*rmbs_pkg::ColW+1:0] dxx;
	logic signed [2*rmbs_pkg::ColW+1:0] dyy;
	logic [rmbs_pkg::D2W-1:0]           d2;
	logic [rmbs_pkg::VW-1:0]            res_bit;
	logic                               sq_take;
	logic [rmbs_pkg::DistW-1:0]         dist_fx;
	logic [rmbs_pkg::DistW-1:0]         in8;
	logic [rmbs_pkg::DistW-1:0]         ddiff;
	logic [rmbs_pkg::NumW-1:0]          num;
	logic [rmbs_pkg::DenW-1:0]          den;
	logic                               at_inner;
	logic                               flat_ramp;
	logic                               ramp_full;
	logic                               div_take;
	logic [rmbs_pkg::PixW:0]            sum9;
	logic [rmbs_pkg::PixW-1:0]          sum_sat;
	logic [rmbs_pkg::LinW-1:0]          lin;
	logic [rmbs_pkg::AddrW-1:0]         addr;
	logic [rmbs_pkg::PixW-1:0]          rdata;
	logic [rmbs_pkg::PixW-1:0]          bg;
	logic [rmbs_pkg::PixW-1:0]          adiff;
	logic                               ram_we;
	logic [rmbs_pkg::AddrW-1:0]         ram_waddr;
	logic [rmbs_pkg::PixW-1:0]          ram_wdata;

	// Squared distance to the centre.
	always_comb begin
		dx  = $signed({1'b0, item_q.col}) - $signed({1'b0, cfg_regs.center_x});
		dy  = $signed({2'b0, item_q.row}) - $signed({1'b0, cfg_regs.center_y});
		dxx = dx * dx;
		dyy = dy * dy;
		d2  = dxx[rmbs_pkg::D2W-1:0] + dyy[rmbs_pkg::D2W-1:0];
	end

	// One digit of the square root per cycle.
	assign res_bit = res_q + bit_q;
	assign sq_take = (v_q >= res_bit);

	// Ramp classification and division set-up.
	always_comb begin
		dist_fx   = res_q[rmbs_pkg::DistW-1:0];
		in8       = {1'b0, cfg_regs.inner_radius, 8'b0};
		ddiff     = dist_fx - in8;
		num       = ({ddiff, 8'b0}) - rmbs_pkg::NumW'(ddiff);
		den       = {cfg_regs.outer_radius - cfg_regs.inner_radius, 8'b0};
		at_inner  = (dist_fx <= in8);
		flat_ramp = (cfg_regs.outer_radius <= cfg_regs.inner_radius);
		ramp_full = (num >= {1'b0, den, 8'b0});
		div_take  = (rem_q >= dsh_q);
	end

	// Saturating add and store address.
	always_comb begin
		sum9    = {1'b0, item_q.pixel} + {1'b0, mask_q};
		sum_sat = sum9[rmbs_pkg::PixW] ? '1 : sum9[rmbs_pkg::PixW-1:0];
		lin     = rmbs_pkg::LinW'(item_q.row) * rmbs_pkg::LinW'(rmbs_pkg::MaxWidth)
			+ rmbs_pkg::LinW'(item_q.col);
		if (({1'b0, item_q.col} < (rmbs_pkg::ColW+1)'(rmbs_pkg::MaxWidth))
			&& (lin < rmbs_pkg::LinW'(rmbs_pkg::BgDepth))) begin
			addr = lin[rmbs_pkg::AddrW-1:0];
		end else begin
			addr = '0;
		end
	end

	// Background comparison; a captured pixel compares against itself.
	always_comb begin
		bg    = item_q.capture_bg ? sum_q : rdata;
		adiff = (sum_q >= bg) ? sum_q - bg : bg - sum_q;
	end

	// Store write: the clearing pass after reset, or a capture.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = sum_q;
		if (state_q == rmbs_pkg::ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (state_q == rmbs_pkg::ST_CMP) begin
			ram_we = item_q.capture_bg;
		end
	end

	rmbs_ram #(
		.Width (rmbs_pkg::PixW),
		.Depth (rmbs_pkg::BgDepth)
	) u_bg_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (addr),
		.rdata (rdata)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rmbs_pkg::ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == rmbs_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// Next state and handshake outputs.
	always_comb begin
		state_d              = state_q;
		pop                  = 1'b0;
		back_status.clearing = (state_q == rmbs_pkg::ST_CLEAR);
		results.valid        = (state_q == rmbs_pkg::ST_OUT);
		unique case (state_q)
			rmbs_pkg::ST_CLEAR: begin
				if (clr_q == rmbs_pkg::AddrW'(rmbs_pkg::BgDepth - 1)) begin
					state_d = rmbs_pkg::ST_IDLE;
				end
			end
			rmbs_pkg::ST_IDLE: begin
				if (!q_status.empty) begin
					pop     = 1'b1;
					state_d = rmbs_pkg::ST_SQR;
				end
			end
			rmbs_pkg::ST_SQR: begin
				state_d = rmbs_pkg::ST_SQRT;
			end
			rmbs_pkg::ST_SQRT: begin
				if (bit_q[0]) begin
					state_d = rmbs_pkg::ST_RAMP;
				end
			end
			rmbs_pkg::ST_RAMP: begin
				if (at_inner || flat_ramp || ramp_full) begin
					state_d = rmbs_pkg::ST_MEM;
				end else begin
					state_d = rmbs_pkg::ST_DIV;
				end
			end
			rmbs_pkg::ST_DIV: begin
				if (dcnt_q == 3'd7) begin
					state_d = rmbs_pkg::ST_MEM;
				end
			end
			rmbs_pkg::ST_MEM: begin
				state_d = rmbs_pkg::ST_CMP;
			end
			rmbs_pkg::ST_CMP: begin
				state_d = rmbs_pkg::ST_OUT;
			end
			rmbs_pkg::ST_OUT: begin
				if (results.ready) begin
					state_d = rmbs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rmbs_pkg::ST_IDLE;
			end
		endcase
	end

	// Datapath registers, stepped by the state.
	always_ff @(posedge clk) begin
		unique case (state_q)
			rmbs_pkg::ST_IDLE: begin
				item_q <= head;
			end
			rmbs_pkg::ST_SQR: begin
				v_q   <= {d2, 16'b0};
				res_q <= '0;
				bit_q <= rmbs_pkg::VW'(1) << (rmbs_pkg::VW - 1);
			end
			rmbs_pkg::ST_SQRT: begin
				if (sq_take) begin
					v_q   <= v_q - res_bit;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			rmbs_pkg::ST_RAMP: begin
				if (at_inner) begin
					mask_q <= '0;
				end else if (flat_ramp || ramp_full) begin
					mask_q <= '1;
				end else begin
					mask_q <= '0;
				end
				rem_q  <= num;
				dsh_q  <= rmbs_pkg::NumW'(den) << 7;
				dcnt_q <= '0;
			end
			rmbs_pkg::ST_DIV: begin
				if (div_take) begin
					rem_q <= rem_q - dsh_q;
				end
				mask_q <= {mask_q[rmbs_pkg::PixW-2:0], div_take};
				dsh_q  <= dsh_q >> 1;
				dcnt_q <= dcnt_q + 1'b1;
			end
			rmbs_pkg::ST_MEM: begin
				sum_q  <= sum_sat;
				addr_q <= addr;
			end
			rmbs_pkg::ST_CMP: begin
				fg_q <= (adiff > cfg_regs.threshold) ? '1 : '0;
			end
			default: begin
			end
		endcase
	end

	assign results.foreground   = fg_q;
	assign results.masked_pixel = sum_q;
	assign results.mask_value   = mask_q;
	assign results.frame_end    = item_q.frame_end;

	`RMBS_ASSERT_NOW(a_capture_not_fg, results.valid && item_q.capture_bg, results.foreground == '0)
	`RMBS_ASSERT_NOW(a_no_pop_in_clear, back_status.clearing, !pop)
	`RMBS_ASSERT_NEXT(a_pop_starts_sqr, pop, state_q == rmbs_pkg::ST_SQR)
endmodule

@@ rtl/radial_mask_background_subtract.sv @@
// Radial mask background subtraction: a gray pixel stream gets a radial ramp added to it and
// is compared against a stored background frame. The front part tracks raster position and
// queues up to four requests; the back part handles one request at a time, with a 19-step
// iterative square root and, for pixels inside the ramp, an 8-step division for the mask;
// each result is held until it is taken. After reset the background store is zeroed by a
// clearing pass over all 307200 entries, during which no pixel is accepted; register writes
// are taken at any time.
module radial_mask_background_subtract (
	input  logic       clk,
	input  logic       arst_n,
	rmbs_pix_if.sink   pixels,
	rmbs_res_if.source results,
	rmbs_cfg_if.sink   cfg
);
	rmbs_pkg::cfg_t         cfg_q;
	rmbs_pkg::q_status_t    q_status;
	rmbs_pkg::back_status_t back_status;
	rmbs_pkg::item_t        push_item;
	rmbs_pkg::item_t        head;
	logic                   push;
	logic                   pop;

	assign cfg.ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x     <= rmbs_pkg::ColW'(320);
			cfg_q.center_y     <= rmbs_pkg::ColW'(240);
			cfg_q.inner_radius <= rmbs_pkg::RadW'(250);
			cfg_q.outer_radius <= rmbs_pkg::RadW'(350);
			cfg_q.threshold    <= rmbs_pkg::ThrW'(60);
			cfg_q.frame_width  <= rmbs_pkg::ColW'(640);
			cfg_q.frame_height <= rmbs_pkg::RowW'(480);
		end else if (cfg.valid) begin
			unique case (rmbs_pkg::cfg_idx_t'(cfg.index))
				rmbs_pkg::CFG_CENTER_X:     cfg_q.center_x     <= cfg.data;
				rmbs_pkg::CFG_CENTER_Y:     cfg_q.center_y     <= cfg.data;
				rmbs_pkg::CFG_INNER_RADIUS: cfg_q.inner_radius <= cfg.data;
				rmbs_pkg::CFG_OUTER_RADIUS: cfg_q.outer_radius <= cfg.data;
				rmbs_pkg::CFG_THRESHOLD:    cfg_q.threshold    <= cfg.data[rmbs_pkg::ThrW-1:0];
				rmbs_pkg::CFG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg.data;
				rmbs_pkg::CFG_FRAME_HEIGHT: cfg_q.frame_height <= cfg.data[rmbs_pkg::RowW-1:0];
				default: begin
				end
			endcase
		end
	end

	rmbs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixels      (pixels),
		.cfg_regs    (cfg_q),
		.q_status    (q_status),
		.back_status (back_status),
		.push        (push),
		.push_item   (push_item)
	);

	rmbs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	rmbs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_regs    (cfg_q),
		.q_status    (q_status),
		.head        (head),
		.pop         (pop),
		.back_status (back_status),
		.results     (results)
	);
endmodule

@@ sim/tb_radial_mask_background_subtract.sv @@
// Self-checking testbench for the radial mask background subtraction block.
`timescale 1ns / 100ps

module tb_radial_mask_background_subtract;
	localparam int ClkHalf   = 10;
	localparam int CycleCap  = 2500000;
	localparam int RandItems = 1500;
	localparam int Phases    = 12;

	typedef struct {
		logic [7:0] foreground;
		logic [7:0] masked_pixel;
		logic [7:0] mask_value;
		logic       frame_end;
	} pix_result_t;

	// Shadow of the block: registers, raster counters, background store and pending results.
	class mask_scoreboard;
		int unsigned cx, cy, inner, outer, thr, fw, fh;
		int unsigned col_cnt, row_cnt;
		byte unsigned bg[rmbs_pkg::BgDepth];
		pix_result_t pending_results[$];
		int errors;

		function new();
			cx = 320; cy = 240; inner = 250; outer = 350; thr = 60; fw = 640; fh = 480;
			col_cnt = 0; row_cnt = 0; errors = 0;
			foreach (bg[i]) bg[i] = 0;
		endfunction

		function void set_reg(rmbs_pkg::cfg_idx_t idx, int unsigned v);
			case (idx)
				rmbs_pkg::CFG_CENTER_X: cx = v & 'h3ff;
				rmbs_pkg::CFG_CENTER_Y: cy = v & 'h3ff;
				rmbs_pkg::CFG_INNER_RADIUS: inner = v & 'h3ff;
				rmbs_pkg::CFG_OUTER_RADIUS: outer = v & 'h3ff;
				rmbs_pkg::CFG_THRESHOLD: thr = v & 'hff;
				rmbs_pkg::CFG_FRAME_WIDTH: fw = v & 'h3ff;
				rmbs_pkg::CFG_FRAME_HEIGHT: fh = v & 'h1ff;
				default: ;
			endcase
		endfunction

		// Bitwise integer square root.
		function longint unsigned int_root(longint unsigned v);
			longint unsigned r, b;
			r = 0;
			b = 64'h4000_0000_0000_0000;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		function int unsigned ramp(int unsigned col, int unsigned row);
			longint dx, dy;
			longint unsigned root, in8, q;
			dx = longint'(col) - longint'(cx);
			dy = longint'(row) - longint'(cy);
			root = int_root(longint'(dx * dx + dy * dy) << 16);
			in8 = longint'(inner) << 8;
			if (root <= in8) return 0;
			if (outer <= inner) return 255;
			q = ((root - in8) * 255) / (longint'(outer - inner) << 8);
			return q > 255 ? 255 : int'(q);
		endfunction

		// Works out the result of one accepted pixel request.
		function void note_request(logic [7:0] pixel, logic capture, logic start);
			int unsigned w, h, col, row, m, sum, addr, b, diff;
			bit line_end, f_end;
			pix_result_t r;
			w = fw == 0 ? 1 : (fw > rmbs_pkg::MaxWidth ? rmbs_pkg::MaxWidth : fw);
			h = fh == 0 ? 1 : (fh > rmbs_pkg::MaxHeight ? rmbs_pkg::MaxHeight : fh);
			if (start) begin
				col_cnt = 0;
				row_cnt = 0;
			end
			col = col_cnt;
			row = row_cnt;
			m = ramp(col, row);
			sum = pixel + m;
			if (sum > 255) sum = 255;
			addr = row * rmbs_pkg::MaxWidth + col;
			if (col >= rmbs_pkg::MaxWidth || addr >= rmbs_pkg::BgDepth) addr = 0;
			if (capture) bg[addr] = 8'(sum);
			b = bg[addr];
			diff = sum >= b ? sum - b : b - sum;
			line_end = col + 1 >= w;
			f_end = line_end && (row + 1 >= h);
			if (line_end) begin
				col_cnt = 0;
				row_cnt = f_end ? 0 : ((row + 1) & 'h1ff);
			end else begin
				col_cnt = (col + 1) & 'h3ff;
			end
			r.foreground = diff > thr ? 8'd255 : 8'd0;
			r.masked_pixel = 8'(sum);
			r.mask_value = 8'(m);
			r.frame_end = f_end;
			pending_results.push_back(r);
		endfunction

		task report_mismatch(string what, int unsigned got, int unsigned want);
			$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
			errors++;
		endtask

		task check_result(pix_result_t got);
			pix_result_t want;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				want = pending_results.pop_front();
				if (got.foreground !== want.foreground)
					report_mismatch("foreground", got.foreground, want.foreground);
				if (got.masked_pixel !== want.masked_pixel)
					report_mismatch("masked_pixel", got.masked_pixel, want.masked_pixel);
				if (got.mask_value !== want.mask_value)
					report_mismatch("mask_value", got.mask_value, want.mask_value);
				if (got.frame_end !== want.frame_end)
					report_mismatch("frame_end", got.frame_end, want.frame_end);
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	int unsigned cycle_count;
	bit no_idle;
	mask_scoreboard sb;

	rmbs_pix_if pix ();
	rmbs_res_if res ();
	rmbs_cfg_if cfg ();

	radial_mask_background_subtract dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixels(pix.sink),
		.results(res.source),
		.cfg(cfg.sink)
	);

	// Clock generation.
	always begin
		clk = 1'b0;
		#ClkHalf;
		clk = 1'b1;
		#ClkHalf;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleCap) begin
			$display("tb_radial_mask_background_subtract NOT OK");
			$finish;
		end
	end

	// Short waits, mostly none, occasionally a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic write_reg(rmbs_pkg::cfg_idx_t idx, int unsigned v);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= rmbs_pkg::CfgDataW'(v);
		do @(negedge clk); while (!cfg.ready);
		@(posedge clk);
		cfg.valid <= 1'b0;
		sb.set_reg(idx, v);
	endtask

	task automatic write_all(int unsigned x, y, ri, ro, th, w, h);
		write_reg(rmbs_pkg::CFG_CENTER_X, x);
		write_reg(rmbs_pkg::CFG_CENTER_Y, y);
		write_reg(rmbs_pkg::CFG_INNER_RADIUS, ri);
		write_reg(rmbs_pkg::CFG_OUTER_RADIUS, ro);
		write_reg(rmbs_pkg::CFG_THRESHOLD, th);
		write_reg(rmbs_pkg::CFG_FRAME_WIDTH, w);
		write_reg(rmbs_pkg::CFG_FRAME_HEIGHT, h);
	endtask

	// Drives one pixel request and waits for it to be taken.
	task automatic send_pixel(logic [7:0] p, logic capture, logic start);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			pix.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.pixel <= p;
		pix.capture_bg <= capture;
		pix.frame_start <= start;
		do @(negedge clk); while (!pix.ready);
		@(posedge clk);
		sb.note_request(p, capture, start);
	endtask

	task automatic drain();
		pix.valid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Result side: random back-pressure, sampling at the falling edge.
	initial begin : result_sink
		int unsigned stall_left;
		bit taken;
		pix_result_t got;
		stall_left = 0;
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			taken = res.valid && res.ready;
			if (taken) begin
				got.foreground = res.foreground;
				got.masked_pixel = res.masked_pixel;
				got.mask_value = res.mask_value;
				got.frame_end = res.frame_end;
			end
			@(posedge clk);
			if (taken) sb.check_result(got);
			if (stall_left == 0 && !no_idle) stall_left = pick_gap();
			if (stall_left > 0 && !no_idle) begin
				stall_left--;
				res.ready <= 1'b0;
			end else begin
				stall_left = 0;
				res.ready <= 1'b1;
			end
		end
	end

	// Main sequence: reset, a directed phase, then randomised phases.
	initial begin : stimulus
		int unsigned n_items, ri, ro, w, h, r;
		logic start;
		sb = new();
		cycle_count = 0;
		no_idle = 1'b0;
		arst_n = 1'b0;
		pix.valid = 1'b0;
		pix.pixel = '0;
		pix.capture_bg = 1'b0;
		pix.frame_start = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Small frame with a short ramp: extremes of pixel, capture and compare.
		write_all(2, 1, 0, 2, 0, 5, 3);
		send_pixel(8'd0, 1'b0, 1'b1);
		send_pixel(8'd255, 1'b1, 1'b0);
		send_pixel(8'd128, 1'b1, 1'b0);
		send_pixel(8'd1, 1'b0, 1'b0);
		send_pixel(8'd254, 1'b0, 1'b0);
		for (int i = 0; i < 10; i++) send_pixel(8'(i * 25), i[0], 1'b0);
		send_pixel(8'd255, 1'b0, 1'b1);
		send_pixel(8'd0, 1'b0, 1'b0);
		send_pixel(8'd127, 1'b1, 1'b1);
		drain();
		// Out-of-range sizes and a degenerate ramp at the far corner.
		write_all(1023, 1023, 1023, 1023, 255, 0, 0);
		send_pixel(8'd200, 1'b0, 1'b1);
		send_pixel(8'd0, 1'b1, 1'b0);
		send_pixel(8'd255, 1'b0, 1'b0);
		drain();
		// Degenerate ramp at the origin with oversized frame registers.
		write_all(0, 0, 0, 0, 255, 1023, 511);
		send_pixel(8'd10, 1'b0, 1'b1);
		send_pixel(8'd10, 1'b0, 1'b0);
		send_pixel(8'd0, 1'b1, 1'b0);
		drain();

		n_items = 0;
		for (int ph = 0; ph < Phases; ph++) begin
			no_idle = (ph % 4 == 3);
			ri = ($urandom_range(0, 9) == 0) ? 1023 : $urandom_range(0, 20);
			r = $urandom_range(0, 9);
			ro = (r < 2) ? $urandom_range(0, ri) : ((r == 2) ? 1023 : ri + $urandom_range(1, 30));
			w = ($urandom_range(0, 4) == 0) ? 1023 - $urandom_range(0, 1) * 383 : $urandom_range(1, 24);
			if ($urandom_range(0, 9) == 0) w = $urandom_range(0, 1) ? 0 : 641;
			h = ($urandom_range(0, 4) == 0) ? 511 - $urandom_range(0, 1) * 31 : $urandom_range(1, 12);
			if ($urandom_range(0, 9) == 0) h = $urandom_range(0, 1) ? 0 : 481;
			r = $urandom_range(0, 3);
			write_all($urandom_range(0, 1) ? $urandom_range(0, 30) : $urandom_range(0, 1023),
				$urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 1023),
				ri, ro, r == 0 ? 0 : (r == 1 ? 255 : $urandom_range(0, 255)), w, h);
			for (int i = 0; i < RandItems / Phases; i++) begin
				if (ph == 5 && i == 60) drain();
				// Mostly well-formed frames, with the odd stray or missing start.
				start = (sb.col_cnt == 0 && sb.row_cnt == 0) ? ($urandom_range(0, 9) != 0)
					: ($urandom_range(0, 29) == 0);
				send_pixel(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, start);
				n_items++;
			end
			drain();
		end

		no_idle = 1'b0;
		if (sb.errors == 0 && sb.pending_results.size() == 0) begin
			$display("tb_radial_mask_background_subtract OK");
		end else begin
			$display("tb_radial_mask_background_subtract NOT OK");
		end
		$finish;
	end
endmodule
